// ===== hw/rtl/bfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes of the best-fit aligned allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  typedef struct packed {
    logic        func;
    logic [31:0] req_bytes;
    logic [8:0]  align_bytes;
    logic [31:0] free_addr;
  } alloc_req_t;

  typedef struct packed {
    logic [31:0] granted_addr;
    logic [1:0]  status;
  } alloc_rsp_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_OUT_POOL = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_BYTES = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_GAP,
    OP_PAD,
    OP_EVA,
    OP_EVB,
    OP_SH_INIT,
    OP_READ_PREV,
    OP_WRITE_SHIFT,
    OP_INSERT,
    OP_IDX_INC,
    OP_READ_NEXT,
    OP_WRITE_DEL,
    OP_DEC,
    OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] rsp_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic table_full;
    logic out_of_pool;
    logic at_count;
    logic rem_done;
    logic found;
    logic hit;
    logic shift_done;
    logic del_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfa_rem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_rem
// Remainder of a 32-bit address by a 9-bit alignment, eight bits per cycle.
// ----------------------------------------------------------------------------
module bfa_rem (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [31:0] dividend,
  input  wire logic [8:0]  divisor,
  output logic             done,
  output logic [8:0]       rem
);

  logic [31:0] q;
  logic [8:0]  r;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] q_next;
  logic [8:0]  r_next;

  always_comb begin
    logic [9:0] t;
    q_next = q;
    r_next = r;
    for (int k = 0; k < 8; k++) begin
      t = {r_next, q_next[31]};
      q_next = {q_next[30:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        r_next = 9'(t - {1'b0, divisor});
      end else begin
        r_next = t[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= dividend;
      r <= '0;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign rem = r;

endmodule
`default_nettype wire

// ===== hw/rtl/bfa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: pool registers, entry table, gap evaluation and result register.
// ----------------------------------------------------------------------------
module bfa_dp
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire alloc_req_t req,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  output alloc_rsp_t      rsp
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [31:0] pool_base;
  logic [31:0] pool_bytes;
  logic [63:0] tbl [MAX_ENTRIES];
  logic [63:0] rd_data;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;

  logic        func;
  logic [31:0] req_bytes;
  logic [8:0]  align;
  logic [31:0] free_addr;
  logic [31:0] prev;
  logic [31:0] gap;
  logic        gap_neg;
  logic [8:0]  pad;
  logic [32:0] usable;
  logic [31:0] cand;
  logic        found;
  logic [31:0] best_use;
  logic [31:0] best_start;
  logic [CW-1:0] best_pos;

  logic [32:0] end_sum;
  logic [31:0] endp;
  logic [31:0] hi;
  logic        rem_done;
  logic [8:0]  rem;
  logic        we;
  logic [AW-1:0] wa;
  logic [63:0] wd;
  logic [AW-1:0] ra;
  logic        re;
  logic [CW:0] idx_inc;

  assign end_sum = {1'b0, pool_base} + {1'b0, pool_bytes};
  assign endp    = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
  assign hi      = stat.at_count ? endp : rd_data[63:32];
  assign idx_inc = {1'b0, idx} + (CW + 1)'(1);

  bfa_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.op == OP_GAP),
    .dividend (prev),
    .divisor  (align),
    .done     (rem_done),
    .rem      (rem)
  );

  always_comb begin
    stat.is_free     = (func == FUNC_FREE);
    stat.too_large   = (req_bytes > pool_bytes);
    stat.table_full  = (count == CW'(MAX_ENTRIES));
    stat.out_of_pool = (free_addr < pool_base) || (free_addr > endp);
    stat.at_count    = (idx == count);
    stat.rem_done    = rem_done;
    stat.found       = found;
    stat.hit         = (rd_data[63:32] == free_addr);
    stat.shift_done  = (idx == best_pos);
    stat.del_done    = (idx_inc == {1'b0, count});
  end

  // Table port selection
  always_comb begin
    re = 1'b0;
    ra = idx[AW-1:0];
    we = 1'b0;
    wa = idx[AW-1:0];
    wd = rd_data;
    case (cmd.op)
      OP_READ: begin
        re = 1'b1;
      end
      OP_READ_PREV: begin
        re = 1'b1;
        ra = AW'(idx - CW'(1));
      end
      OP_READ_NEXT: begin
        re = 1'b1;
        ra = AW'(idx_inc);
      end
      OP_WRITE_SHIFT, OP_WRITE_DEL: begin
        we = 1'b1;
      end
      OP_INSERT: begin
        we = 1'b1;
        wa = best_pos[AW-1:0];
        wd = {best_start, best_start + req_bytes};
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[wa] <= wd;
    end
    if (re) begin
      rd_data <= tbl[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_bytes <= '0;
      count      <= '0;
      found      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_BASE) begin
          pool_base <= cfg_data;
        end else begin
          pool_bytes <= cfg_data;
        end
      end
      case (cmd.op)
        OP_LOAD: found <= 1'b0;
        OP_EVB: begin
          if (!usable[32] && !gap_neg && usable[31:0] >= req_bytes &&
              (!found || usable[31:0] < best_use)) begin
            found <= 1'b1;
          end
        end
        OP_INSERT: count <= count + CW'(1);
        OP_DEC:    count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        func      <= req.func;
        req_bytes <= req.req_bytes;
        align     <= (req.align_bytes == 9'd0) ? 9'd1 : req.align_bytes;
        free_addr <= req.free_addr;
        idx       <= '0;
        prev      <= pool_base;
      end
      OP_GAP: begin
        gap_neg <= (hi < prev);
        gap     <= hi - prev;
      end
      OP_PAD: pad <= (rem == 9'd0) ? 9'd0 : align - rem;
      OP_EVA: begin
        usable <= {1'b0, gap} - {24'd0, pad};
        cand   <= prev + {23'd0, pad};
      end
      OP_EVB: begin
        if (!usable[32] && !gap_neg && usable[31:0] >= req_bytes &&
            (!found || usable[31:0] < best_use)) begin
          best_use   <= usable[31:0];
          best_start <= cand;
          best_pos   <= idx;
        end
        prev <= rd_data[31:0];
        if (!stat.at_count) begin
          idx <= idx + CW'(1);
        end
      end
      OP_SH_INIT:                  idx <= count;
      OP_WRITE_SHIFT:              idx <= idx - CW'(1);
      OP_IDX_INC, OP_WRITE_DEL:    idx <= idx + CW'(1);
      OP_RESP: begin
        rsp.status       <= cmd.rsp_status;
        rsp.granted_addr <= (cmd.rsp_status == STATUS_OK && func == FUNC_ALLOC) ?
                            best_start : 32'd0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bfa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller: sequences gap scan, table shifts and the result beat.
// ----------------------------------------------------------------------------
module bfa_ctrl
  import bfa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          done,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_A_RD, S_A_GAP, S_A_MOD, S_A_EVA, S_A_EVB, S_A_DONE,
    S_A_SHC, S_A_SHW, S_A_INS, S_F_RD, S_F_CMP, S_F_DC, S_F_DW, S_RESP
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] code;
  logic [1:0] code_next;

  always_comb begin
    state_next     = state;
    code_next      = code;
    cmd.op         = OP_NONE;
    cmd.rsp_status = code;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_free) begin
          if (stat.out_of_pool) begin
            code_next  = STATUS_OUT_POOL;
            state_next = S_RESP;
          end else begin
            state_next = S_F_RD;
          end
        end else if (stat.too_large) begin
          code_next  = STATUS_NO_FIT;
          state_next = S_RESP;
        end else if (stat.table_full) begin
          code_next  = STATUS_FULL;
          state_next = S_RESP;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.op     = OP_READ;
        state_next = S_A_GAP;
      end
      S_A_GAP: begin
        cmd.op     = OP_GAP;
        state_next = S_A_MOD;
      end
      S_A_MOD: begin
        if (stat.rem_done) begin
          cmd.op     = OP_PAD;
          state_next = S_A_EVA;
        end
      end
      S_A_EVA: begin
        cmd.op     = OP_EVA;
        state_next = S_A_EVB;
      end
      S_A_EVB: begin
        cmd.op     = OP_EVB;
        state_next = stat.at_count ? S_A_DONE : S_A_RD;
      end
      S_A_DONE: begin
        if (!stat.found) begin
          code_next  = STATUS_NO_FIT;
          state_next = S_RESP;
        end else begin
          cmd.op     = OP_SH_INIT;
          state_next = S_A_SHC;
        end
      end
      S_A_SHC: begin
        if (stat.shift_done) begin
          state_next = S_A_INS;
        end else begin
          cmd.op     = OP_READ_PREV;
          state_next = S_A_SHW;
        end
      end
      S_A_SHW: begin
        cmd.op     = OP_WRITE_SHIFT;
        state_next = S_A_SHC;
      end
      S_A_INS: begin
        cmd.op     = OP_INSERT;
        code_next  = STATUS_OK;
        state_next = S_RESP;
      end
      S_F_RD: begin
        if (stat.at_count) begin
          code_next  = STATUS_OK;
          state_next = S_RESP;
        end else begin
          cmd.op     = OP_READ;
          state_next = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (stat.hit) begin
          state_next = S_F_DC;
        end else begin
          cmd.op     = OP_IDX_INC;
          state_next = S_F_RD;
        end
      end
      S_F_DC: begin
        if (stat.del_done) begin
          cmd.op     = OP_DEC;
          code_next  = STATUS_OK;
          state_next = S_RESP;
        end else begin
          cmd.op     = OP_READ_NEXT;
          state_next = S_F_DW;
        end
      end
      S_F_DW: begin
        cmd.op     = OP_WRITE_DEL;
        state_next = S_F_DC;
      end
      S_RESP: begin
        cmd.op     = OP_RESP;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= STATUS_OK;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      done  <= (state == S_RESP);
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/best_fit_aligned_allocator_core.sv =====
`default_nettype none
// Allocate scans table entries + 1 gaps, each one waiting on the remainder unit,
//   then shifts the later entries up one place and inserts the new entry.
// Free scans the entries for the address and moves the later entries down.
// One item at a time; busy stays high until the done beat is issued.
// Reset (rst, synchronous): table empty, pool registers zero, no beat pending.
// The receiver cannot stall: done is high for exactly one cycle per item.
// ----------------------------------------------------------------------------
// best_fit_aligned_allocator_core
// Best-fit allocator over one pool with aligned starts and a sorted table.
// ----------------------------------------------------------------------------
module best_fit_aligned_allocator_core
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire alloc_req_t  req,
  // result beat
  output logic             done,
  output alloc_rsp_t       rsp,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration is always taken; the user must write it only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  // Sequence scan, shift and response steps.
  bfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Hold the table, pool registers and the result register.
  bfa_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free commands into the best-fit allocator, predicts
// every result from a local copy of the allocation table, and checks each
// done beat field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench
  import bfa_pkg::*;
();

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 20000;

  // Scoreboard: table model plus the queue of predicted responses.
  class alloc_scoreboard;
    bit [31:0]  base_q, bytes_q;
    bit [31:0]  ent_lo[TABLE_DEPTH];
    bit [31:0]  ent_hi[TABLE_DEPTH];
    int         live;
    alloc_rsp_t pending[$];
    int         mismatches;

    function void set_reg(logic idx, bit [31:0] val);
      if (idx == CFG_POOL_BASE) base_q = val;
      else bytes_q = val;
    endfunction

    // Test one gap [lo, hi) for an aligned fit.
    function bit gap_ok(longint unsigned lo, longint unsigned hi, longint unsigned al,
                        longint unsigned need, output longint unsigned room,
                        output longint unsigned at);
      longint unsigned span, pad;
      room = 0;
      at = 0;
      if (hi < lo) return 0;
      span = hi - lo;
      pad = (lo % al) ? al - (lo % al) : 0;
      if (pad > span) return 0;
      if (span - pad < need) return 0;
      room = span - pad;
      at = lo + pad;
      return 1;
    endfunction

    // Note an accepted command: update the table and queue its response.
    function void note_cmd(alloc_req_t r);
      alloc_rsp_t o;
      longint unsigned top, prev, al, need, room, at, best_room, best_at;
      int best_pos, i;
      bit hit;
      o = '0;
      top = longint'(base_q) + longint'(bytes_q);
      if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
      if (r.func == FUNC_ALLOC) begin
        al = (r.align_bytes == 0) ? 1 : r.align_bytes;
        need = r.req_bytes;
        prev = base_q;
        hit = 0;
        best_room = 0;
        best_at = 0;
        best_pos = 0;
        if (r.req_bytes > bytes_q) o.status = STATUS_NO_FIT;
        else if (live >= TABLE_DEPTH) o.status = STATUS_FULL;
        else begin
          for (i = 0; i < live; i++) begin
            if (gap_ok(prev, ent_lo[i], al, need, room, at) && (!hit || room < best_room)) begin
              hit = 1; best_room = room; best_at = at; best_pos = i;
            end
            prev = ent_hi[i];
          end
          if (gap_ok(prev, top, al, need, room, at) && (!hit || room < best_room)) begin
            hit = 1; best_room = room; best_at = at; best_pos = live;
          end
          if (!hit) o.status = STATUS_NO_FIT;
          else begin
            for (i = live; i > best_pos; i--) begin
              ent_lo[i] = ent_lo[i-1];
              ent_hi[i] = ent_hi[i-1];
            end
            ent_lo[best_pos] = best_at[31:0];
            ent_hi[best_pos] = 32'(best_at + need);
            live++;
            o.granted_addr = best_at[31:0];
          end
        end
      end else if (r.free_addr < base_q || r.free_addr > top) begin
        o.status = STATUS_OUT_POOL;
      end else begin
        for (i = 0; i < live; i++) begin
          if (ent_lo[i] == r.free_addr) begin
            for (int j = i; j + 1 < live; j++) begin
              ent_lo[j] = ent_lo[j+1];
              ent_hi[j] = ent_hi[j+1];
            end
            live--;
            break;
          end
        end
      end
      pending = {pending, o};
    endfunction

    function void check_rsp(alloc_rsp_t got);
      alloc_rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: addr %h status %0d",
                                       got.granted_addr, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.granted_addr !== want.granted_addr || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                   want.granted_addr, want.status, got.granted_addr, got.status);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        start, busy, done;
  alloc_req_t  req;
  alloc_rsp_t  rsp;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;

  alloc_scoreboard sb;
  int unsigned idle_cycles;
  bit          quiet_phase;   // no idling in the last stretch of the run
  bit [31:0]   live_addrs[$]; // granted addresses, used to aim frees

  best_fit_aligned_allocator_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Check every done beat; bump the watchdog when nothing moves.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_rsp(rsp);
      if (rsp.status == STATUS_OK && rsp.granted_addr != 0)
        live_addrs = {live_addrs, rsp.granted_addr};
    end
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold start while the block is busy, and drop it only when a gap follows.
  task automatic send_cmd(alloc_req_t r);
    int gap;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd(r);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait out every outstanding beat, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Present one register beat and hold it until taken; valid stays up.
  task automatic write_reg(logic idx, bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_pool(bit [31:0] b, bit [31:0] n);
    write_reg(CFG_POOL_BASE, b);
    write_reg(CFG_POOL_BYTES, n);
    cfg_valid <= 1'b0;
    live_addrs.delete();
  endtask

  function automatic alloc_req_t mk_alloc(bit [31:0] n, bit [8:0] al);
    alloc_req_t r;
    r = '0;
    r.func = FUNC_ALLOC;
    r.req_bytes = n;
    r.align_bytes = al;
    r.free_addr = $urandom;
    return r;
  endfunction

  function automatic alloc_req_t mk_free(bit [31:0] a);
    alloc_req_t r;
    r = '0;
    r.func = FUNC_FREE;
    r.req_bytes = $urandom;
    r.align_bytes = 9'($urandom);
    r.free_addr = a;
    return r;
  endfunction

  // Random item biased toward small requests and frees of live addresses.
  function automatic alloc_req_t rand_item(bit [31:0] b, bit [31:0] n);
    bit [31:0] sz, a;
    bit [8:0]  al;
    int pick;
    pick = $urandom_range(0, 99);
    al = (pick % 10 == 0) ? 9'($urandom) : 9'($urandom_range(1, 256));
    if (pick < 55) begin
      sz = (pick < 5) ? $urandom : $urandom_range(0, (n >> 3) + 1);
      return mk_alloc(sz, al);
    end
    if (pick < 85 && live_addrs.size() != 0) begin
      a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      return mk_free(a);
    end
    if (pick < 93) a = b + $urandom_range(0, n);
    else a = $urandom;
    return mk_free(a);
  endfunction

  initial begin
    alloc_req_t r;
    bit [31:0] pb, pn;
    sb = new();
    idle_cycles = 0;
    quiet_phase = 0;
    rst = 1;
    start = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = CFG_POOL_BASE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero-size pool first, then extreme fields and special cases.
    send_cmd(mk_alloc(0, 1));
    send_cmd(mk_alloc(1, 1));
    send_cmd(mk_free(0));
    send_cmd(mk_free(1));
    drain();
    set_pool(32'h0000_1003, 32'h0000_0400);
    send_cmd(mk_alloc(32'hFFFF_FFFF, 9'd256));   // too large
    send_cmd(mk_alloc(0, 9'd0));                 // zero alignment, zero size
    send_cmd(mk_alloc(32'h40, 9'd256));
    send_cmd(mk_alloc(32'h10, 9'h1FF));          // alignment above 256
    send_cmd(mk_alloc(32'h400, 9'd1));           // whole pool, no fit now
    send_cmd(mk_free(32'h0000_1002));            // below pool
    send_cmd(mk_free(32'h0000_1403));            // pool end itself
    send_cmd(mk_free(32'h0000_1404));            // past pool end
    send_cmd(mk_free(32'h0000_1100));            // starts a live entry
    send_cmd(mk_free(32'h0000_1003));
    for (int i = 0; i < 17; i++) send_cmd(mk_alloc(4, 9'd4)); // fill to full
    drain();
    // Saturating pool end, then shrink the pool under live entries.
    set_pool(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_cmd(mk_alloc(32'h80, 9'd128));
    send_cmd(mk_free(32'hFFFF_FFFF));
    send_cmd(mk_alloc(0, 9'd256));
    drain();
    set_pool(32'h0000_1200, 32'h0000_0100);
    send_cmd(mk_alloc(8, 9'd8));
    drain();

    // Random phases with varied pool settings; the last one runs without gaps.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: begin pb = $urandom_range(0, 255); pn = $urandom_range(64, 4096); end
        1: begin pb = $urandom; pn = $urandom_range(0, 65535); end
        2: begin pb = 32'h0; pn = 32'hFFFF_FFFF; end
        default: begin pb = $urandom; pn = $urandom; end
      endcase
      if (ph == 13) quiet_phase = 1;
      if (ph % 5 != 4) set_pool(pb, pn);
      else begin pb = sb.base_q; pn = sb.bytes_q; end
      for (int k = 0; k < 125; k++) begin
        r = rand_item(pb, pn);
        send_cmd(r);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
